### sv/rps_pkg.sv
// rtos_priority_scheduler package: sizes, payload structs, operation codes
// no dependencies
`default_nettype none
package rps_pkg;
	localparam int Threads = 8;
	localparam int Semaphores = 8;
	localparam int Events = 4;
	localparam int TidW = 3;
	localparam int SidW = 3;

	typedef enum logic [2:0] {
		FN_ADD = 3'd0, FN_FIRST = 3'd1, FN_SINIT = 3'd2, FN_SIGNAL = 3'd3,
		FN_WAIT = 3'd4, FN_SLEEP = 3'd5, FN_SCHED = 3'd6, FN_TICK = 3'd7
	} func_t;

	localparam logic [2:0] REG_CEIL = 3'd0;
	localparam logic [2:0] REG_PER0 = 3'd1;
	localparam logic [2:0] REG_PER1 = 3'd2;
	localparam logic [2:0] REG_PER2 = 3'd3;
	localparam logic [2:0] REG_PER3 = 3'd4;

	typedef struct packed {
		logic [2:0]         func;
		logic [2:0]         thread_id;
		logic [2:0]         next_thread_id;
		logic [7:0]         priority_req;
		logic [2:0]         sem_id;
		logic signed [15:0] sem_value;
		logic [31:0]        sleep_ticks;
	} in_word_t;

	typedef struct packed {
		logic [2:0]         running_thread;
		logic               idle;
		logic signed [15:0] sem_count;
		logic               woken_valid;
		logic [2:0]         woken_thread;
		logic [3:0]         fired_events;
	} out_word_t;
endpackage
`default_nettype wire

### sv/rps_divchk.sv
// rtos_priority_scheduler: serial divisibility check, one quotient bit per cycle
// depends on rps_pkg
`default_nettype none
module rps_divchk
	import rps_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic             divides
);
	logic [32:0] rem_q;
	logic [31:0] dvd_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {rem_q[31:0], dvd_q[31]};
	assign diff = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
			rem_q <= '0;
			dvd_q <= '0;
			dvs_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
				rem_q <= '0;
				dvd_q <= dividend;
				dvs_q <= divisor;
			end else if (busy_q) begin
				rem_q <= diff[32] ? shifted : diff;
				dvd_q <= {dvd_q[30:0], 1'b0};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	assign divides = (rem_q == '0);
endmodule
`default_nettype wire

### sv/rtos_priority_scheduler.sv
// rtos_priority_scheduler top level: thread ring, semaphores, sleep and tick logic
// depends on rps_pkg and rps_divchk
`default_nettype none
// One operation per input word, one result word per operation. Add, set
// first, semaphore init and a signal or wait that needs no ring walk go
// from accept through S_EXEC to S_DONE, where the result can be taken; a
// signal that walks the ring looks at one thread per cycle until it wakes
// a thread blocked on that semaphore or has seen all threads; a reschedule
// walks the ring too. A tick that does not wrap the tick counter runs each
// nonzero event period through one serial divisibility unit and counts all
// sleep counters down together with the last event. in_stall is high while
// an operation is in work or its result waits in the output register.
module rtos_priority_scheduler
	import rps_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_word_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_word_t      out_data,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [31:0] cfg_data
);
	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_WALK, S_DIV, S_DIVW, S_DONE
	} state_t;

	state_t state_q;
	in_word_t req_q;
	logic [TidW-1:0] ring_q [Threads];
	logic [7:0]      prio_q [Threads];
	logic            blk_q [Threads];
	logic [SidW-1:0] bsem_q [Threads];
	logic [31:0]     slp_q [Threads];
	logic signed [15:0] sem_q [Semaphores];
	logic [TidW-1:0] cur_q;
	logic [31:0]     tick_q;
	logic [7:0]      ceil_q;
	logic [31:0]     per_q [Events];

	logic [TidW-1:0] p_q, pick_q;
	logic [7:0]      best_q;
	logic            found_q;
	logic [3:0]      n_q;
	logic            sigwalk_q;
	logic [1:0]      ev_q;
	logic [3:0]      fired_q;
	logic signed [15:0] scnt_q;
	logic            wv_q;
	logic [TidW-1:0] wt_q;
	logic            idle_q;

	logic            dstart, ddone, ddiv;
	logic [TidW-1:0] np;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_DONE);
	assign np = ring_q[p_q];
	assign dstart = (state_q == S_DIV) && per_q[ev_q] != '0;

	assign out_data.running_thread = cur_q;
	assign out_data.idle = idle_q;
	assign out_data.sem_count = scnt_q;
	assign out_data.woken_valid = wv_q;
	assign out_data.woken_thread = wt_q;
	assign out_data.fired_events = fired_q;

	rps_divchk u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .dividend(tick_q),
		.divisor(per_q[ev_q]), .done(ddone), .divides(ddiv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q <= '0;
			for (int i = 0; i < Threads; i++) begin
				ring_q[i] <= TidW'(i + 1);
				prio_q[i] <= 8'hff;
				blk_q[i] <= 1'b0;
				bsem_q[i] <= '0;
				slp_q[i] <= '0;
			end
			for (int i = 0; i < Semaphores; i++) sem_q[i] <= '0;
			for (int i = 0; i < Events; i++) per_q[i] <= '0;
			cur_q <= '0;
			tick_q <= '0;
			ceil_q <= 8'hff;
			p_q <= '0; pick_q <= '0; best_q <= '0; found_q <= 1'b0;
			n_q <= '0; sigwalk_q <= 1'b0; ev_q <= '0; fired_q <= '0;
			scnt_q <= '0; wv_q <= 1'b0; wt_q <= '0; idle_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_CEIL) ceil_q <= cfg_data[7:0];
				else if (cfg_index >= REG_PER0 && cfg_index <= REG_PER3)
					per_q[2'(cfg_index - REG_PER0)] <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q <= in_data;
						idle_q <= 1'b0; scnt_q <= '0; wv_q <= 1'b0;
						wt_q <= '0; fired_q <= '0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					p_q <= cur_q; pick_q <= cur_q; best_q <= ceil_q;
					found_q <= 1'b0; n_q <= '0; sigwalk_q <= 1'b0;
					state_q <= S_DONE;
					case (func_t'(req_q.func))
						FN_ADD: begin
							ring_q[req_q.thread_id] <= req_q.next_thread_id;
							prio_q[req_q.thread_id] <= req_q.priority_req;
							blk_q[req_q.thread_id] <= 1'b0;
							bsem_q[req_q.thread_id] <= '0;
							slp_q[req_q.thread_id] <= '0;
						end
						FN_FIRST: cur_q <= req_q.thread_id;
						FN_SINIT: begin
							sem_q[req_q.sem_id] <= req_q.sem_value;
							scnt_q <= req_q.sem_value;
						end
						FN_SIGNAL: begin
							if (sem_q[req_q.sem_id] != 16'sh7fff) begin
								sem_q[req_q.sem_id] <= sem_q[req_q.sem_id] + 16'sd1;
								scnt_q <= sem_q[req_q.sem_id] + 16'sd1;
								if (sem_q[req_q.sem_id] + 16'sd1 <= 16'sd0) begin
									sigwalk_q <= 1'b1;
									state_q <= S_WALK;
								end
							end else scnt_q <= sem_q[req_q.sem_id];
						end
						FN_WAIT: begin
							if (sem_q[req_q.sem_id] != 16'sh8000) begin
								sem_q[req_q.sem_id] <= sem_q[req_q.sem_id] - 16'sd1;
								scnt_q <= sem_q[req_q.sem_id] - 16'sd1;
							end else scnt_q <= sem_q[req_q.sem_id];
							if (sem_q[req_q.sem_id] <= 16'sd0) begin
								blk_q[cur_q] <= 1'b1;
								bsem_q[cur_q] <= req_q.sem_id;
								state_q <= S_WALK;
							end
						end
						FN_SLEEP: begin
							slp_q[cur_q] <= req_q.sleep_ticks;
							state_q <= S_WALK;
						end
						FN_SCHED: state_q <= S_WALK;
						default: begin
							tick_q <= tick_q + 32'd1;
							ev_q <= '0;
							if (tick_q != 32'hffffffff) state_q <= S_DIV;
						end
					endcase
				end
				S_WALK: begin
					p_q <= np;
					n_q <= n_q + 4'd1;
					if (sigwalk_q) begin
						if (blk_q[np] && bsem_q[np] == req_q.sem_id) begin
							blk_q[np] <= 1'b0;
							wv_q <= 1'b1; wt_q <= np;
							state_q <= S_DONE;
						end else if (n_q == 4'(Threads - 1)) state_q <= S_DONE;
					end else begin
						if (prio_q[np] < best_q && !blk_q[np] && slp_q[np] == '0) begin
							best_q <= prio_q[np]; pick_q <= np; found_q <= 1'b1;
						end
						if (n_q == 4'(Threads)) begin
							state_q <= S_DONE;
							if (found_q) cur_q <= pick_q;
							idle_q <= !found_q;
						end
					end
				end
				S_DIV: begin
					if (per_q[ev_q] != '0) state_q <= S_DIVW;
					else if (ev_q == 2'(Events - 1)) begin
						for (int i = 0; i < Threads; i++)
							if (slp_q[i] != '0) slp_q[i] <= slp_q[i] - 32'd1;
						state_q <= S_DONE;
					end else ev_q <= ev_q + 2'd1;
				end
				S_DIVW: begin
					if (ddone) begin
						if (ddiv) fired_q[ev_q] <= 1'b1;
						state_q <= S_DIV;
						if (ev_q == 2'(Events - 1)) begin
							for (int i = 0; i < Threads; i++)
								if (slp_q[i] != '0) slp_q[i] <= slp_q[i] - 32'd1;
							state_q <= S_DONE;
						end else ev_q <= ev_q + 2'd1;
					end
				end
				S_DONE: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### sv/rps_checker.sv
// rtos_priority_scheduler port checker and its bind
// depends on rps_pkg
`default_nettype none
module rps_checker
	import rps_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_word_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out hold");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("stall during result");
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !out_valid) else $error("accept");
	a_wok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.woken_valid |-> out_data.woken_thread == '0)
		else $error("woken");
endmodule

bind rtos_priority_scheduler rps_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.out_data(out_data)
);
`default_nettype wire
